>>> src/awgn_pkg.sv
// shared types, constants and opcodes for the awgn noise adder
`timescale 1ns / 1ps

package awgn_pkg;

   // opcodes
   localparam logic [1:0] OP_SAMPLE     = 2'd0;
   localparam logic [1:0] OP_NOISE_UP   = 2'd1;
   localparam logic [1:0] OP_NOISE_DOWN = 2'd2;

   // generator
   localparam logic [31:0] LCG_MUL   = 32'd1103515245;
   localparam logic [31:0] LCG_INC   = 32'd12345;
   localparam logic [31:0] SEED_INIT = 32'd1;
   localparam int DRAW_W     = 15;
   localparam int DRAW_COUNT = 16;
   localparam int CNT_W      = $clog2(DRAW_COUNT);
   localparam logic [CNT_W-1:0] DRAW_LAST = CNT_W'(DRAW_COUNT - 1);

   // sum and centring
   localparam int SUM_W    = 19;
   localparam int CENTRE_W = SUM_W + 1;
   localparam logic signed [CENTRE_W-1:0] CENTRE_OFFSET = 20'sd262136;
   localparam int MAG_W    = 18;

   // gain
   localparam int GAIN_W = 24;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd25322;
   localparam logic [GAIN_W-1:0] GAIN_MAX   = 24'hFFFFFF;
   localparam int Q_SHIFT   = 16;
   localparam int PROD_W    = MAG_W + GAIN_W;
   localparam int NOISE_W   = PROD_W - Q_SHIFT;
   // floor(x / 3) = (x * ceil(2^27 / 3)) >> 27 for any x below 2^27
   localparam int DIV3_SHIFT = 27;
   localparam logic [25:0] DIV3_RECIP = 26'd44739243;
   localparam int DIV3_W = GAIN_W + 1 + 26;

   // output range
   localparam int TOTAL_W = NOISE_W + 2;
   localparam logic signed [TOTAL_W-1:0] SAMPLE_MAX = 28'sd32767;
   localparam logic signed [TOTAL_W-1:0] SAMPLE_MIN = -28'sd32768;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] sample_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               clipped;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW,
      ST_CENTRE,
      ST_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_sample;
      logic gain_up;
      logic gain_down;
      logic draw_step;
      logic centre;
      logic multiply;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

>>> src/awgn_ctrl.sv
// sequencer for the awgn noise adder: draws, centring, scaling, output
`timescale 1ns / 1ps

module awgn_ctrl
   import awgn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_opcode,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid && (req_opcode == OP_SAMPLE)) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DRAW_LAST) begin
               state_in = ST_CENTRE;
            end
         end
         ST_CENTRE: state_in = ST_MUL;
         ST_MUL:    state_in = ST_DONE;
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_opcode)
                  OP_SAMPLE:     cmd.load_sample = 1'b1;
                  OP_NOISE_UP:   cmd.gain_up     = 1'b1;
                  OP_NOISE_DOWN: cmd.gain_down   = 1'b1;
                  default:       cmd             = '0;
               endcase
            end
         end
         ST_DRAW:   cmd.draw_step = 1'b1;
         ST_CENTRE: cmd.centre    = 1'b1;
         ST_MUL:    cmd.multiply  = 1'b1;
         ST_DONE:   cmd.load_out  = status.out_free;
         default:   cmd           = '0;
      endcase
   end

endmodule

>>> src/awgn_dp.sv
// datapath for the awgn noise adder: generator, sum, gain, scale, saturate
`timescale 1ns / 1ps

module awgn_dp
   import awgn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic [31:0]              seed_ff, seed_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]       sample_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic                     neg_ff;
   logic [NOISE_W-1:0]       noise_ff;
   rsp_type                  rsp_ff, rsp_in;

   logic [31:0]              seed_next;
   logic signed [CENTRE_W-1:0] centred;
   logic signed [CENTRE_W-1:0] centred_abs;
   logic [PROD_W-1:0]        prod;
   logic [GAIN_W:0]          gain_up_wide;
   logic [DIV3_W-1:0]        div_prod;
   logic signed [TOTAL_W-1:0] noise_s;
   logic signed [TOTAL_W-1:0] total;

   // generator step, one draw a cycle
   assign seed_next = seed_ff * LCG_MUL + LCG_INC;

   always_comb begin
      centred     = $signed({1'b0, sum_ff}) - CENTRE_OFFSET;
      centred_abs = centred[CENTRE_W-1] ? -centred : centred;
      prod        = PROD_W'(mag_ff) * PROD_W'(gain_ff);
   end

   // gain * 3/2 saturated, gain * 2/3 through the reciprocal of three
   always_comb begin
      gain_up_wide = {1'b0, gain_ff} + {2'b00, gain_ff[GAIN_W-1:1]};
      div_prod     = DIV3_W'({gain_ff, 1'b0}) * DIV3_W'(DIV3_RECIP);
      gain_in      = gain_ff;
      if (cmd.gain_up) begin
         gain_in = gain_up_wide[GAIN_W] ? GAIN_MAX : gain_up_wide[GAIN_W-1:0];
      end else if (cmd.gain_down) begin
         gain_in = div_prod[DIV3_SHIFT +: GAIN_W];
      end
   end

   // sample plus signed noise, saturated
   always_comb begin
      noise_s = neg_ff ? -$signed({2'b00, noise_ff}) : $signed({2'b00, noise_ff});
      total   = TOTAL_W'(sample_ff) + noise_s;
      priority if (total > SAMPLE_MAX) begin
         rsp_in.sample_out = 16'sh7FFF;
         rsp_in.clipped    = 1'b1;
      end else if (total < SAMPLE_MIN) begin
         rsp_in.sample_out = -16'sh8000;
         rsp_in.clipped    = 1'b1;
      end else begin
         rsp_in.sample_out = total[15:0];
         rsp_in.clipped    = 1'b0;
      end
   end

   always_comb begin
      seed_in      = cmd.draw_step ? seed_next : seed_ff;
      status.out_free = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SEED_INIT;
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= req_data.sample_in;
         sum_ff    <= '0;
      end
      if (cmd.draw_step) begin
         sum_ff <= sum_ff + SUM_W'(seed_next[30:16]);
      end
      if (cmd.centre) begin
         mag_ff <= centred_abs[MAG_W-1:0];
         neg_ff <= centred[CENTRE_W-1];
      end
      if (cmd.multiply) begin
         noise_ff <= prod[PROD_W-1:Q_SHIFT];
      end
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/awgn_channel_noise_adder_top.sv
// top level of the awgn noise adder: sequencer, datapath and checks
`timescale 1ns / 1ps

// Adds Gaussian-like noise to signed Q15 samples. Each sample beat (opcode 0)
// takes sixteen 15-bit draws from a 32-bit linear congruential generator
// (seed * 1103515245 + 12345, bits 30..16), sums and centres them, scales the
// sum by the Q16 gain (truncating toward zero), adds it to the sample and
// saturates to 16 bits, flagging clipped when saturation happened. A sample
// beat is accepted in idle and then occupies the block for sixteen draws
// (the generator multiply-add is a loop-carried dependency, one step a
// cycle), then centring, the gain multiply and the final add. The result
// sits in an output register, so the next beat is accepted as soon as the
// block is back in idle even if that result has not yet been taken; only a
// second result waits for the first to leave. Noise-up (opcode 1, gain * 3/2
// saturating at 0xFFFFFF) and noise-down (opcode 2, gain * 2/3) beats are
// handled in idle and give no result; opcode 3 is accepted and ignored.
// After reset the gain is 25322 and the seed is 1.

module awgn_channel_noise_adder_top
   import awgn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer: walks idle, draw x16, centre, multiply, done
   awgn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: generator, accumulator, gain register, scaler, output register
   awgn_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a sample beat keeps the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.opcode == OP_SAMPLE)) |=> !req_ready)
      else $error("block accepted a beat while drawing noise");

   // exactly sixteen draws between a sample beat and centring
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.opcode == OP_SAMPLE)) |-> ##17 cmd.centre)
      else $error("draw count wrong");

   // a pending result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("output register overwritten");

   // gain only moves on a gain beat
   assert property (@(posedge clock) disable iff (reset)
      (!cmd.gain_up && !cmd.gain_down) |=> $stable(u_dp.gain_ff))
      else $error("gain changed without a gain beat");

endmodule

>>> sim/awgn_channel_noise_adder_top_test.sv
// testbench for the awgn noise adder: directed and random beats against a local predictor
`timescale 1ns / 1ps

module awgn_channel_noise_adder_top_test;
   import awgn_pkg::*;

   // opcode 3 has no name in the package; the block takes it and drops it
   localparam logic [1:0]  OP_IGNORED    = 2'd3;

   // generator and gain constants, kept separate from the design's own copies
   localparam logic [31:0] RNG_MULT      = 32'd1103515245;
   localparam logic [31:0] RNG_ADD       = 32'd12345;
   localparam int          DRAWS_PER_SAMPLE = 16;
   localparam logic signed [20:0] CENTRE_BIAS = 21'sd262136;   // 8 * 32767
   localparam logic [23:0] GAIN_AT_RESET = 24'd25322;
   localparam logic [23:0] GAIN_CEILING  = 24'hFFFFFF;

   // a sample beat holds the block through its draws, so these limits are very loose
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_BEATS  = 1550;
   localparam int REPORT_LIMIT  = 10;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // predictor state, a copy of what the block should hold
   logic [31:0] lcg_state;
   logic [23:0] gain_q16;
   rsp_type     pending_samples[$];

   // shared between the sender, the receiver and the test tasks
   bit zero_gaps     = 1'b0;
   int stall_request = 0;

   // bookkeeping for the final report
   int fail_count      = 0;
   int samples_checked = 0;
   int clipped_seen    = 0;
   int gain_steps      = 0;
   int cycle_count     = 0;
   logic [23:0] gain_peak = 24'd0;

   awgn_channel_noise_adder_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run guard: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, pending_samples.size());
         $display("awgn_channel_noise_adder_top verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // one generator step; the draw is bits 30..16 of the new state
   function automatic logic [14:0] next_draw();
      lcg_state = lcg_state * RNG_MULT + RNG_ADD;
      return lcg_state[30:16];
   endfunction

   // applies one accepted beat to the predicted state and queues the result it owes
   function automatic void model_awgn_beat(input req_type beat);
      logic [25:0]        gain_wide;
      logic [19:0]        draw_sum;
      logic signed [20:0] centred;
      logic [19:0]        magnitude;
      logic [47:0]        scaled;
      logic signed [31:0] noise;
      logic signed [31:0] total;
      rsp_type            result;
      case (beat.opcode)
         OP_NOISE_UP: begin
            // gain * 3/2, floored, pinned at the register maximum
            gain_wide = (26'(gain_q16) * 26'd3) >> 1;
            gain_q16  = (gain_wide > 26'(GAIN_CEILING)) ? GAIN_CEILING : gain_wide[23:0];
            gain_steps++;
         end
         OP_NOISE_DOWN: begin
            // gain * 2/3, floored; zero stays at zero
            gain_wide = (26'(gain_q16) * 26'd2) / 26'd3;
            gain_q16  = gain_wide[23:0];
            gain_steps++;
         end
         OP_SAMPLE: begin
            draw_sum = '0;
            for (int k = 0; k < DRAWS_PER_SAMPLE; k++)
               draw_sum += 20'(next_draw());
            centred   = $signed({1'b0, draw_sum}) - CENTRE_BIAS;
            magnitude = (centred < 0) ? 20'(-centred) : 20'(centred);
            // scale the magnitude so the truncation goes toward zero
            scaled    = 48'(magnitude) * 48'(gain_q16);
            noise     = $signed(32'(scaled >> 16));
            if (centred < 0)
               noise = -noise;
            total = beat.sample_in + noise;
            result.clipped = 1'b0;
            if (total > 32767) begin
               total          = 32767;
               result.clipped = 1'b1;
            end else if (total < -32768) begin
               total          = -32768;
               result.clipped = 1'b1;
            end
            result.sample_out = total[15:0];
            pending_samples.push_back(result);
         end
         default: ;   // unused opcode: no state change, no result
      endcase
      if (gain_q16 > gain_peak)
         gain_peak = gain_q16;
   endfunction

   // ------------------------------------------------------------------
   // failure reporting: the first few in full, the rest only counted
   // ------------------------------------------------------------------
   function automatic void flag_problem(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("[%0t] %s", $realtime, msg);
   endfunction

   // ------------------------------------------------------------------
   // result side: ready pattern and the per-beat check
   // ------------------------------------------------------------------

   // receiver: random hold-off per beat, plus a long hold on request
   initial begin : rsp_side
      int wait_cycles;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         wait_cycles   = zero_gaps ? 0 : $urandom_range(0, 5);
         wait_cycles  += stall_request;
         stall_request = 0;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         // hold ready until a beat is taken, or until a long hold is asked for
         do @(posedge clock); while (!rsp_valid && stall_request == 0);
         @(negedge clock);
      end
   end

   // every accepted result is compared with the oldest prediction
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            flag_problem($sformatf("result with nothing owed: sample_out %0d clipped %0b",
                                   rsp_data.sample_out, rsp_data.clipped));
         end else begin
            want = pending_samples.pop_front();
            samples_checked++;
            if (want.clipped)
               clipped_seen++;
            if (rsp_data.sample_out !== want.sample_out)
               flag_problem($sformatf("sample_out mismatch: expected %0d, got %0d",
                                      want.sample_out, rsp_data.sample_out));
            if (rsp_data.clipped !== want.clipped)
               flag_problem($sformatf("clipped mismatch: expected %0b, got %0b",
                                      want.clipped, rsp_data.clipped));
         end
      end
   end

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // offers one beat after a random gap; valid stays high until it is taken
   task automatic send_beat(input logic [1:0] opcode, input logic signed [15:0] value);
      req_type beat;
      int      gap;
      beat.opcode    = opcode;
      beat.sample_in = value;
      gap = zero_gaps ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      model_awgn_beat(beat);
   endtask

   // drops valid before the next edge so the last beat is not taken twice
   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // sample values that lean on the saturation edges now and then
   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom);
         1:       return 16'sd32767 - 16'($urandom_range(0, 2000));
         2:       return -16'sd32768 + 16'($urandom_range(0, 2000));
         default: return 16'($signed($urandom_range(0, 4000)) - 2000);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // full-scale and bit-pattern samples at the reset gain, plus the unused opcode
   task automatic test_sample_extremes();
      send_beat(OP_SAMPLE, 16'sd32767);
      send_beat(OP_SAMPLE, -16'sd32768);
      send_beat(OP_SAMPLE, 16'sd0);
      send_beat(OP_SAMPLE, 16'sd1);
      send_beat(OP_SAMPLE, -16'sd1);
      send_beat(OP_SAMPLE, 16'h5555);
      send_beat(OP_SAMPLE, 16'hAAAA);
      // opcode 3 must leave the generator and gain alone
      send_beat(OP_IGNORED, 16'h7FFF);
      send_beat(OP_IGNORED, 16'h8000);
      send_beat(OP_SAMPLE, 16'sd1000);
      release_req();
   endtask

   // single and paired gain steps each way, with a sample after each group
   task automatic test_gain_steps();
      send_beat(OP_NOISE_UP, 16'hFFFF);
      send_beat(OP_SAMPLE, 16'sd0);
      send_beat(OP_NOISE_DOWN, 16'h0000);
      send_beat(OP_SAMPLE, 16'sd0);
      send_beat(OP_NOISE_DOWN, 16'h8001);
      send_beat(OP_NOISE_DOWN, 16'h7FFE);
      send_beat(OP_SAMPLE, -16'sd20000);
      send_beat(OP_NOISE_UP, 16'h1234);
      send_beat(OP_NOISE_UP, 16'hEDCB);
      send_beat(OP_SAMPLE, 16'sd20000);
      release_req();
   endtask

   // drive the gain into its ceiling, try once more, then bring it back down
   task automatic test_gain_ceiling();
      for (int n = 0; n < 30 && gain_q16 != GAIN_CEILING; n++)
         send_beat(OP_NOISE_UP, 16'($urandom));
      // with the largest gain almost every sample saturates
      repeat (4) send_beat(OP_SAMPLE, pick_sample());
      send_beat(OP_NOISE_UP, 16'($urandom));
      send_beat(OP_SAMPLE, 16'sd0);
      send_beat(OP_SAMPLE, -16'sd1);
      for (int n = 0; n < 40 && gain_q16 > GAIN_AT_RESET; n++)
         send_beat(OP_NOISE_DOWN, 16'($urandom));
      release_req();
   endtask

   // hold the result side for a long stretch while samples keep coming,
   // so the output register fills and the input stalls
   task automatic test_output_backpressure();
      zero_gaps     = 1'b1;
      stall_request = 300;
      repeat (8) send_beat(OP_SAMPLE, pick_sample());
      send_beat(OP_NOISE_UP, 16'sd0);
      send_beat(OP_SAMPLE, pick_sample());
      release_req();
      zero_gaps = 1'b0;
   endtask

   // mostly samples with a random walk of the gain, in gappy and back-to-back stretches
   task automatic test_random_traffic();
      int counted;
      int pick;
      counted = 0;
      while (counted < RANDOM_BEATS) begin
         if (counted % 50 == 0)
            zero_gaps = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            send_beat(OP_SAMPLE, pick_sample());
            counted++;
         end else if (pick < 94) begin
            // keep the walk away from zero, which would end all noise
            if (gain_q16 < 24'd2048)
               send_beat(OP_NOISE_UP, 16'($urandom));
            else if (gain_q16 > 24'd4000000)
               send_beat(OP_NOISE_DOWN, 16'($urandom));
            else if ($urandom_range(0, 1) == 1)
               send_beat(OP_NOISE_UP, 16'($urandom));
            else
               send_beat(OP_NOISE_DOWN, 16'($urandom));
            counted++;
         end else begin
            send_beat(OP_IGNORED, 16'($urandom));
         end
      end
      release_req();
      zero_gaps = 1'b0;
   endtask

   // run the gain down to zero; samples then pass through untouched and
   // neither step direction can bring the gain back
   task automatic test_gain_floor();
      for (int n = 0; n < 64 && gain_q16 != 24'd0; n++)
         send_beat(OP_NOISE_DOWN, 16'($urandom));
      send_beat(OP_SAMPLE, 16'sd32767);
      send_beat(OP_SAMPLE, -16'sd32768);
      send_beat(OP_NOISE_DOWN, 16'sd0);
      send_beat(OP_NOISE_UP, 16'sd0);
      repeat (4) send_beat(OP_SAMPLE, pick_sample());
      send_beat(OP_IGNORED, 16'sd0);
      send_beat(OP_SAMPLE, 16'sd0);
      release_req();
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      lcg_state = 32'd1;
      gain_q16  = GAIN_AT_RESET;
      gain_peak = GAIN_AT_RESET;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_sample_extremes();
      test_gain_steps();
      test_gain_ceiling();
      test_output_backpressure();
      test_random_traffic();
      test_gain_floor();

      // let every owed result come back, then a little longer for strays
      while (pending_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_samples.size() != 0)
         flag_problem($sformatf("%0d results never arrived", pending_samples.size()));

      $display("covered %0d noisy samples (%0d saturated) and %0d gain steps",
               samples_checked, clipped_seen, gain_steps);
      $display("gain ranged from zero up to %0d, with one long output hold; %0d cycles",
               gain_peak, cycle_count);
      if (fail_count == 0) begin
         $display("awgn_channel_noise_adder_top verification clean");
      end else begin
         $display("%0d problems found", fail_count);
         $display("awgn_channel_noise_adder_top verification failed");
      end
      $finish;
   end

endmodule
